// File: hw/rtl/stpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpr_pkg
// types and constants shared by the trapezoidal ramp core
// ----------------------------------------------------------------------------
package stpr_pkg;

    typedef enum logic [1:0] {
        ACT_GOTO = 2'd0,
        ACT_STOP = 2'd1,
        ACT_TICK = 2'd2,
        ACT_STEP = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        PH_STOP   = 4'b0001,
        PH_ACCEL  = 4'b0010,
        PH_CRUISE = 4'b0100,
        PH_BRAKE  = 4'b1000
    } phase_t;

    typedef enum logic [1:0] {
        REG_SLOWEST = 2'd0,
        REG_FASTEST = 2'd1,
        REG_DELTA   = 2'd2,
        REG_CURRENT = 2'd3
    } reg_idx_t;

    localparam logic [1:0]  PHASE_CODE_STOP   = 2'd0;
    localparam logic [1:0]  PHASE_CODE_ACCEL  = 2'd1;
    localparam logic [1:0]  PHASE_CODE_CRUISE = 2'd2;
    localparam logic [1:0]  PHASE_CODE_BRAKE  = 2'd3;

    localparam logic [11:0] HOLD_CURRENT      = 12'd64;
    localparam logic [15:0] SLOWEST_RESET     = 16'd1000;
    localparam logic [15:0] FASTEST_RESET     = 16'd200;
    localparam logic [15:0] DELTA_RESET       = 16'd10;
    localparam logic [11:0] CURRENT_RESET     = 12'd1000;

    typedef struct packed {
        logic [15:0] slowest_period;
        logic [15:0] fastest_period;
        logic [15:0] ramp_delta;
        logic [11:0] run_current;
    } cfg_t;

    typedef struct packed {
        logic [15:0] step_period;
        logic        step_clock_on;
        logic [11:0] drive_current;
        logic        turn_direction;
        logic [1:0]  phase;
        logic        move_done;
    } result_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        code = PHASE_CODE_STOP;
        unique case (ph)
            PH_STOP:   code = PHASE_CODE_STOP;
            PH_ACCEL:  code = PHASE_CODE_ACCEL;
            PH_CRUISE: code = PHASE_CODE_CRUISE;
            PH_BRAKE:  code = PHASE_CODE_BRAKE;
            default:   code = PHASE_CODE_STOP;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/stepper_trapezoid_ramp_core.sv
`timescale 1ns / 1ps
// an accepted item is held in the input register, and its result is then registered in the result register
// throughput: one item per cycle while res_stall does not hold the result register, set by
//   the single-pass update between the input register and the result register
// the result register holds a finished item while the input register takes the next
// reset: asynchronous active-low; move stopped, period 1000, current 64, registers at defaults
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_core
// trapezoidal speed ramp for a stepper drive, top level
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_core
    import stpr_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        cmd_valid,
    output logic        cmd_stall,
    input  logic [1:0]  action,
    input  logic [15:0] step_count,
    input  logic        direction,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [15:0] step_period,
    output logic        step_clock_on,
    output logic [11:0] drive_current,
    output logic        turn_direction,
    output logic [1:0]  phase,
    output logic        move_done
);

    cfg_t        cfg;
    result_t     result;
    result_t     res_reg;
    logic        res_valid_reg;
    logic        in_valid_reg;
    logic [1:0]  action_reg;
    logic [15:0] count_reg;
    logic        dir_reg;
    logic        advance;
    logic        cmd_take;

    assign advance   = in_valid_reg && (!res_valid_reg || !res_stall);
    assign cmd_stall = in_valid_reg && !advance;
    assign cmd_take  = cmd_valid && !cmd_stall;

    stpr_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    stpr_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_en    (advance),
        .action     (action_reg),
        .step_count (count_reg),
        .direction  (dir_reg),
        .cfg        (cfg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
        begin
            action_reg <= action;
            count_reg  <= step_count;
            dir_reg    <= direction;
        end
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign res_valid      = res_valid_reg;
    assign step_period    = res_reg.step_period;
    assign step_clock_on  = res_reg.step_clock_on;
    assign drive_current  = res_reg.drive_current;
    assign turn_direction = res_reg.turn_direction;
    assign phase          = res_reg.phase;
    assign move_done      = res_reg.move_done;

    // an item only moves on when the result register is free or being emptied
    a_advance_room: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!res_valid_reg || !res_stall))
        else $error("item overwrote a waiting result");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (in_valid_reg && res_valid_reg))
        else $error("command stalled with room available");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> (res_valid_reg && $stable(res_reg)))
        else $error("stalled result lost");

endmodule

// File: hw/rtl/stpr_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpr_cfg
// apb register file holding the ramp settings
// ----------------------------------------------------------------------------
module stpr_cfg
    import stpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SLOWEST: cfg_next.slowest_period = pwdata[15:0];
                REG_FASTEST: cfg_next.fastest_period = pwdata[15:0];
                REG_DELTA:   cfg_next.ramp_delta     = pwdata[15:0];
                REG_CURRENT: cfg_next.run_current    = pwdata[11:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SLOWEST: prdata = 32'(cfg_reg.slowest_period);
            REG_FASTEST: prdata = 32'(cfg_reg.fastest_period);
            REG_DELTA:   prdata = 32'(cfg_reg.ramp_delta);
            REG_CURRENT: prdata = 32'(cfg_reg.run_current);
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slowest_period <= SLOWEST_RESET;
            cfg_reg.fastest_period <= FASTEST_RESET;
            cfg_reg.ramp_delta     <= DELTA_RESET;
            cfg_reg.run_current    <= CURRENT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/stpr_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stpr_ctrl
// move state and single-pass next-state logic for one item
// ----------------------------------------------------------------------------
module stpr_ctrl
    import stpr_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_en,
    input  logic [1:0]  action,
    input  logic [15:0] step_count,
    input  logic        direction,
    input  cfg_t        cfg,
    output result_t     result
);

    localparam int LEN_WIDTH = COUNT_WIDTH + 3;
    localparam logic [COUNT_WIDTH-1:0]      CNT_ONE   = COUNT_WIDTH'(1);
    localparam logic signed [LEN_WIDTH-1:0] LEN_THREE = LEN_WIDTH'(3);

    phase_t                  phase_reg,  phase_next;
    logic [15:0]             period_reg, period_next;
    logic [COUNT_WIDTH-1:0]  target_reg, target_next;
    logic [COUNT_WIDTH-1:0]  moved_reg,  moved_next;
    logic [COUNT_WIDTH-1:0]  cruise_reg, cruise_next;
    logic [COUNT_WIDTH-1:0]  clen_reg,   clen_next;
    logic                    ramp_reg,   ramp_next;
    logic                    clock_reg,  clock_next;
    logic                    dir_reg,    dir_next;
    logic [11:0]             current_reg, current_next;
    logic                    done;

    logic [COUNT_WIDTH-1:0]      count_w;
    logic [15:0]                 dec_period;
    logic [16:0]                 inc_period;
    logic signed [LEN_WIDTH-1:0] len_w;

    assign count_w    = COUNT_WIDTH'(step_count);
    assign dec_period = (period_reg > cfg.ramp_delta) ? (period_reg - cfg.ramp_delta) : 16'd0;
    assign inc_period = {1'b0, period_reg} + {1'b0, cfg.ramp_delta};
    // target_last + 1 - 2 * (moved + 2)
    assign len_w      = $signed({3'b000, target_reg}) - $signed({2'b00, moved_reg, 1'b0})
                        - LEN_THREE;

    always_comb
    begin
        phase_next   = phase_reg;
        period_next  = period_reg;
        target_next  = target_reg;
        moved_next   = moved_reg;
        cruise_next  = cruise_reg;
        clen_next    = clen_reg;
        ramp_next    = ramp_reg;
        clock_next   = clock_reg;
        dir_next     = dir_reg;
        current_next = current_reg;
        done         = 1'b0;

        unique case (action_t'(action))
            ACT_GOTO:
            begin
                target_next  = count_w - CNT_ONE;
                dir_next     = direction;
                moved_next   = '0;
                cruise_next  = '0;
                current_next = cfg.run_current;
                period_next  = cfg.slowest_period;
                phase_next   = PH_ACCEL;
                ramp_next    = 1'b1;
                clock_next   = 1'b1;
            end
            ACT_STOP:
            begin
                done         = (phase_reg != PH_STOP);
                clock_next   = 1'b0;
                ramp_next    = 1'b0;
                current_next = HOLD_CURRENT;
                phase_next   = PH_STOP;
            end
            ACT_TICK:
            begin
                if (ramp_reg && phase_reg == PH_ACCEL)
                begin
                    if (dec_period <= cfg.fastest_period)
                    begin
                        cruise_next = '0;
                        period_next = cfg.fastest_period;
                        if (len_w[LEN_WIDTH-1])
                        begin
                            clen_next  = '0;
                            phase_next = PH_BRAKE;
                            ramp_next  = 1'b1;
                        end
                        else
                        begin
                            clen_next  = len_w[COUNT_WIDTH-1:0];
                            phase_next = PH_CRUISE;
                            ramp_next  = 1'b0;
                        end
                    end
                    else
                    begin
                        period_next = dec_period;
                    end
                end
                else if (ramp_reg && phase_reg == PH_BRAKE)
                begin
                    if (inc_period >= {1'b0, cfg.slowest_period})
                    begin
                        period_next = cfg.slowest_period;
                        ramp_next   = 1'b0;
                    end
                    else
                    begin
                        period_next = inc_period[15:0];
                    end
                end
            end
            ACT_STEP:
            begin
                if (clock_reg)
                begin
                    if (moved_reg >= target_reg)
                    begin
                        moved_next = '0;
                        if (phase_reg == PH_BRAKE)
                        begin
                            clock_next   = 1'b0;
                            ramp_next    = 1'b0;
                            current_next = HOLD_CURRENT;
                            phase_next   = PH_STOP;
                            cruise_next  = '0;
                            done         = 1'b1;
                        end
                    end
                    else
                    begin
                        moved_next = moved_reg + CNT_ONE;
                    end
                    if (phase_reg == PH_CRUISE)
                    begin
                        if (cruise_reg >= clen_reg)
                        begin
                            phase_next = PH_BRAKE;
                            ramp_next  = 1'b1;
                        end
                        else
                        begin
                            cruise_next = cruise_reg + CNT_ONE;
                        end
                    end
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result.step_period    = period_next;
        result.step_clock_on  = clock_next;
        result.drive_current  = current_next;
        result.turn_direction = dir_next;
        result.phase          = phase_code(phase_next);
        result.move_done      = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_STOP;
            period_reg  <= SLOWEST_RESET;
            target_reg  <= '0;
            moved_reg   <= '0;
            cruise_reg  <= '0;
            clen_reg    <= '0;
            ramp_reg    <= 1'b0;
            clock_reg   <= 1'b0;
            dir_reg     <= 1'b0;
            current_reg <= HOLD_CURRENT;
        end
        else if (item_en)
        begin
            phase_reg   <= phase_next;
            period_reg  <= period_next;
            target_reg  <= target_next;
            moved_reg   <= moved_next;
            cruise_reg  <= cruise_next;
            clen_reg    <= clen_next;
            ramp_reg    <= ramp_next;
            clock_reg   <= clock_next;
            dir_reg     <= dir_next;
            current_reg <= current_next;
        end
    end

    // step clock runs exactly while a move is in progress
    a_clock_phase: assert property (@(posedge clk) disable iff (!rst_n)
        clock_reg == (phase_reg != PH_STOP))
        else $error("step clock and phase disagree");

    a_accel_ramp: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ACCEL) |-> ramp_reg)
        else $error("accelerating with ramp off");

    a_ramp_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ramp_reg |-> (phase_reg == PH_ACCEL || phase_reg == PH_BRAKE))
        else $error("ramp running outside accelerate or brake");

    a_hold_current: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_STOP) |-> (current_reg == HOLD_CURRENT))
        else $error("stopped without holding current");

endmodule

// File: tb/stepper_trapezoid_ramp_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_core_test
// The testbench drives goto, stop, ramp tick and step items into the ramp core
// and checks every status item that comes out against its own model of the
// move profile. Configuration is programmed and read back over the register
// port between phases while the core is idle. The run starts with a short
// directed move through every phase. Random moves follow under several
// register settings and handshake patterns, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_core_test;
    import stpr_pkg::*;

    class ramp_scoreboard;
        logic [15:0] slowest;
        logic [15:0] fastest;
        logic [15:0] delta;
        logic [11:0] run_cur;
        logic [1:0]  ph;
        logic [15:0] period;
        logic [15:0] target_last;
        logic [15:0] moved;
        logic [15:0] cruise_cnt;
        logic [15:0] cruise_len;
        logic [15:0] ramp_cnt;
        logic        ramp_on;
        logic        clock_on;
        logic        dir;
        logic [11:0] cur;
        result_t     expected_status[$];
        int          failures;

        function new();
            failures    = 0;
            slowest     = SLOWEST_RESET;
            fastest     = FASTEST_RESET;
            delta       = DELTA_RESET;
            run_cur     = CURRENT_RESET;
            ph          = PHASE_CODE_STOP;
            period      = SLOWEST_RESET;
            target_last = '0;
            moved       = '0;
            cruise_cnt  = '0;
            cruise_len  = '0;
            ramp_cnt    = '0;
            ramp_on     = 1'b0;
            clock_on    = 1'b0;
            dir         = 1'b0;
            cur         = HOLD_CURRENT;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_SLOWEST: slowest = value[15:0];
                REG_FASTEST: fastest = value[15:0];
                REG_DELTA:   delta   = value[15:0];
                REG_CURRENT: run_cur = value[11:0];
            endcase
        endfunction

        function void halt_motor();
            clock_on = 1'b0;
            ramp_on  = 1'b0;
            cur      = HOLD_CURRENT;
            ph       = PHASE_CODE_STOP;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            failures++;
        endtask

        // advance the move profile by one accepted item and queue its status
        task note_command(action_t act, logic [15:0] cnt, logic d);
            logic [15:0] shorter;
            logic [16:0] longer;
            int          len;
            logic        done;
            done = 1'b0;
            case (act)
                ACT_GOTO:
                begin
                    target_last = cnt - 16'd1;
                    dir         = d;
                    moved       = '0;
                    cruise_cnt  = '0;
                    cur         = run_cur;
                    period      = slowest;
                    ph          = PHASE_CODE_ACCEL;
                    ramp_on     = 1'b1;
                    clock_on    = 1'b1;
                end
                ACT_STOP:
                begin
                    done = (ph != PHASE_CODE_STOP);
                    halt_motor();
                end
                ACT_TICK:
                begin
                    if (ramp_on && ph == PHASE_CODE_ACCEL)
                    begin
                        shorter = (period > delta) ? period - delta : 16'd0;
                        if (shorter <= fastest)
                        begin
                            ramp_cnt   = moved;
                            cruise_cnt = '0;
                            period     = fastest;
                            ramp_on    = 1'b0;
                            len = int'(target_last) + 1 - 2 * (int'(ramp_cnt) + 2);
                            // too short to cruise: straight into braking
                            if (len < 0)
                            begin
                                cruise_len = '0;
                                ph         = PHASE_CODE_BRAKE;
                                ramp_on    = 1'b1;
                            end
                            else
                            begin
                                cruise_len = 16'(len);
                                ph         = PHASE_CODE_CRUISE;
                            end
                        end
                        else
                        begin
                            period = shorter;
                        end
                    end
                    else if (ramp_on && ph == PHASE_CODE_BRAKE)
                    begin
                        longer = {1'b0, period} + {1'b0, delta};
                        if (longer >= {1'b0, slowest})
                        begin
                            period  = slowest;
                            ramp_on = 1'b0;
                        end
                        else
                        begin
                            period = longer[15:0];
                        end
                    end
                end
                ACT_STEP:
                begin
                    if (clock_on)
                    begin
                        if (moved >= target_last)
                        begin
                            moved = '0;
                            if (ph == PHASE_CODE_BRAKE)
                            begin
                                halt_motor();
                                cruise_cnt = '0;
                                done       = 1'b1;
                            end
                        end
                        else
                        begin
                            moved = moved + 16'd1;
                        end
                        if (ph == PHASE_CODE_CRUISE)
                        begin
                            if (cruise_cnt >= cruise_len)
                            begin
                                ph      = PHASE_CODE_BRAKE;
                                ramp_on = 1'b1;
                            end
                            else
                            begin
                                cruise_cnt = cruise_cnt + 16'd1;
                            end
                        end
                    end
                end
            endcase
            expected_status.push_back('{period, clock_on, cur, dir, ph, done});
        endtask

        task check_status(result_t got);
            result_t want;
            if (expected_status.size() == 0)
            begin
                report("status item with none expected");
            end
            else
            begin
                want = expected_status.pop_front();
                if (got.step_period !== want.step_period)
                    report($sformatf("step_period %0d, expected %0d",
                                     got.step_period, want.step_period));
                if (got.step_clock_on !== want.step_clock_on)
                    report($sformatf("step_clock_on %0b, expected %0b",
                                     got.step_clock_on, want.step_clock_on));
                if (got.drive_current !== want.drive_current)
                    report($sformatf("drive_current %0d, expected %0d",
                                     got.drive_current, want.drive_current));
                if (got.turn_direction !== want.turn_direction)
                    report($sformatf("turn_direction %0b, expected %0b",
                                     got.turn_direction, want.turn_direction));
                if (got.phase !== want.phase)
                    report($sformatf("phase %0d, expected %0d", got.phase, want.phase));
                if (got.move_done !== want.move_done)
                    report($sformatf("move_done %0b, expected %0b",
                                     got.move_done, want.move_done));
            end
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        cmd_valid = 1'b0;
    logic        cmd_stall;
    logic [1:0]  action = '0;
    logic [15:0] step_count = '0;
    logic        direction = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [15:0] step_period;
    logic        step_clock_on;
    logic [11:0] drive_current;
    logic        turn_direction;
    logic [1:0]  phase;
    logic        move_done;

    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        pressure_go = 1'b0;
    logic        hold_off = 1'b0;

    ramp_scoreboard sb = new();

    stepper_trapezoid_ramp_core DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .action         (action),
        .step_count     (step_count),
        .direction      (direction),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .step_period    (step_period),
        .step_clock_on  (step_clock_on),
        .drive_current  (drive_current),
        .turn_direction (turn_direction),
        .phase          (phase),
        .move_done      (move_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        res_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
    end

    // long receiver hold-off so the core backs up and stalls its input
    initial
    begin
        wait (pressure_go);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (80) @(posedge clk);
        hold_off <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                sb.note_command(action_t'(action), step_count, direction);
            if (res_valid && !res_stall)
                sb.check_status('{step_period, step_clock_on, drive_current,
                                  turn_direction, phase, move_done});
        end
    end

    task automatic read_reg(input reg_idx_t idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== want)
            sb.report($sformatf("register %s reads %0h, expected %0h",
                                idx.name(), prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_reg(input reg_idx_t idx, input logic [31:0] value);
        logic [31:0] held;
        held = (idx == REG_CURRENT) ? {20'd0, value[11:0]} : {16'd0, value[15:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_register(idx, value);
        @(posedge clk);
        read_reg(idx, held);
    endtask

    task automatic send_cmd(input action_t act, input logic [15:0] cnt, input logic d);
        int gap;
        gap = 0;
        if ($urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 3);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid  <= 1'b1;
        action     <= act;
        step_count <= cnt;
        direction  <= d;
        @(posedge clk);
        while (cmd_stall) @(posedge clk);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_status.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic random_moves(input int budget);
        int          left;
        int          span;
        int          pick;
        int          i;
        logic [15:0] cnt;
        action_t     act;
        left = budget;
        while (left > 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                cnt = 16'($urandom_range(1, 24));
            else if (pick < 88)
                cnt = 16'($urandom_range(25, 200));
            else if (pick < 92)
                cnt = 16'd0;
            else if (pick < 96)
                cnt = 16'hFFFF;
            else
                cnt = 16'($urandom);
            send_cmd(ACT_GOTO, cnt, 1'($urandom));
            left--;
            span = (cnt != 16'd0 && cnt <= 16'd200) ? 2 * int'(cnt) + 8 : 40;
            for (i = 0; i < span && left > 0; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 46)
                    act = ACT_STEP;
                else if (pick < 92)
                    act = ACT_TICK;
                else if (pick < 97)
                    act = ACT_STOP;
                else
                    act = ACT_GOTO;
                send_cmd(act, 16'($urandom), 1'($urandom));
                left--;
            end
        end
    endtask

    initial
    begin
        logic [15:0] slow_v;
        logic [15:0] fast_v;
        logic [15:0] delta_v;
        logic [11:0] cur_v;
        int          p;
        int          i;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_reg(REG_SLOWEST, {16'd0, SLOWEST_RESET});
        read_reg(REG_FASTEST, {16'd0, FASTEST_RESET});
        read_reg(REG_DELTA, {16'd0, DELTA_RESET});
        read_reg(REG_CURRENT, {20'd0, CURRENT_RESET});

        // short ramp: two ticks reach the fastest period
        program_reg(REG_SLOWEST, 32'd100);
        program_reg(REG_FASTEST, 32'd50);
        program_reg(REG_DELTA, 32'd30);
        program_reg(REG_CURRENT, 32'd4095);

        // idle items while stopped
        send_cmd(ACT_TICK, 16'hFFFF, 1'b1);
        send_cmd(ACT_STEP, 16'h0000, 1'b0);
        send_cmd(ACT_STOP, 16'h5555, 1'b1);
        // full move: accelerate, cruise, brake, final step
        send_cmd(ACT_GOTO, 16'd10, 1'b1);
        send_cmd(ACT_STEP, 16'hAAAA, 1'b0);
        send_cmd(ACT_TICK, 16'h0000, 1'b0);
        send_cmd(ACT_STEP, 16'h0000, 1'b0);
        send_cmd(ACT_TICK, 16'h0000, 1'b0);
        send_cmd(ACT_TICK, 16'h0000, 1'b0);
        for (i = 0; i < 3; i++)
            send_cmd(ACT_STEP, 16'h0000, 1'b0);
        for (i = 0; i < 3; i++)
            send_cmd(ACT_TICK, 16'h0000, 1'b0);
        for (i = 0; i < 5; i++)
            send_cmd(ACT_STEP, 16'h0000, 1'b0);
        // single-step move has no room to cruise
        send_cmd(ACT_GOTO, 16'd1, 1'b0);
        send_cmd(ACT_TICK, 16'h0000, 1'b1);
        send_cmd(ACT_TICK, 16'h0000, 1'b1);
        send_cmd(ACT_STEP, 16'h0000, 1'b1);
        // zero count wraps to the longest move, then abort
        send_cmd(ACT_GOTO, 16'd0, 1'b1);
        send_cmd(ACT_STEP, 16'hFFFF, 1'b0);
        send_cmd(ACT_STOP, 16'h0000, 1'b0);

        for (p = 0; p < 8; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    slow_v  = SLOWEST_RESET;
                    fast_v  = FASTEST_RESET;
                    delta_v = DELTA_RESET;
                    cur_v   = CURRENT_RESET;
                end
                2:
                begin
                    slow_v  = 16'hFFFF;
                    fast_v  = 16'd1;
                    delta_v = 16'hFFFF;
                    cur_v   = 12'd0;
                end
                3:
                begin
                    slow_v  = 16'd1;
                    fast_v  = 16'hFFFF;
                    delta_v = 16'd1;
                    cur_v   = 12'hFFF;
                end
                5:
                begin
                    slow_v  = 16'($urandom);
                    fast_v  = 16'($urandom);
                    delta_v = 16'($urandom);
                    cur_v   = 12'($urandom);
                end
                default:
                begin
                    slow_v  = 16'($urandom_range(20, 300));
                    fast_v  = 16'($urandom_range(1, slow_v));
                    delta_v = 16'($urandom_range(1, 60));
                    cur_v   = 12'($urandom);
                end
            endcase
            program_reg(REG_SLOWEST, {16'd0, slow_v});
            program_reg(REG_FASTEST, {16'd0, fast_v});
            program_reg(REG_DELTA, {16'd0, delta_v});
            program_reg(REG_CURRENT, {20'd0, cur_v});
            case (p % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 47;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 47;
                end
                default:
                begin
                    send_idle_pct = 6;
                    stall_pct     = 6;
                end
            endcase
            if (p == 4)
                pressure_go <= 1'b1;
            random_moves(85);
        end

        wait_idle();
        if (sb.expected_status.size() != 0)
            sb.report($sformatf("%0d expected status items never arrived",
                                sb.expected_status.size()));
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
